// ----- hw/rtl/rwmf_pkg.sv -----
package rwmf_pkg;

    localparam int MAX_KERNEL_DEF = 5;
    localparam int MAX_WIDTH_DEF  = 1024;

    localparam int CH_W   = 8;
    localparam int NUM_CH = 3;
    localparam int PIX_W  = CH_W * NUM_CH;

    localparam int KSIZE_W  = 3;
    localparam int IWIDTH_W = 11;
    localparam int IHEIGHT_W = 16;

    localparam logic [KSIZE_W-1:0]   KSIZE_RST   = 3'd3;
    localparam logic [IWIDTH_W-1:0]  IWIDTH_RST  = 11'd640;
    localparam logic [IHEIGHT_W-1:0] IHEIGHT_RST = 16'd480;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // tuser code for an item that carries a pixel; the other code is a flush
    localparam logic FUNC_PIXEL = 1'b0;

    typedef enum logic [1:0] {
        CFG_KERNEL_SIZE  = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2
    } cfg_idx_t;

endpackage

// ----- hw/rtl/rgb_window_median_filter.sv -----
// A transaction completing a window reaches m_tvalid through the window stage, the sorting
// pipeline (over WINxWIN, WIN being MAX_KERNEL rounded up to odd) and the output register,
// on top of the stream lag of K/2 rows plus K/2 pixels. Throughput: one transaction per cycle
// while m_tready does not hold the pipeline; the line store takes one write and two reads a
// cycle and the median is a pipelined odd-even transposition network, one layer per stage.
// Reset clears the frame counters and all pipeline valids and loads the config registers
// with their defaults; the line store is not cleared.
module rgb_window_median_filter
    import rwmf_pkg::*;
#(
    parameter int MAX_KERNEL = MAX_KERNEL_DEF,
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [PIX_W-1:0]  s_tdata,   // blue_in, green_in, red_in
    input  logic [0:0]        s_tuser,   // func
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [PIX_W-1:0]  m_tdata,   // blue_out, green_out, red_out
    output logic              m_tlast,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int ROW_SLOTS = MAX_KERNEL + 1;
    localparam int SLOT_W    = $clog2(ROW_SLOTS);
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int KW        = $clog2(MAX_KERNEL + 1);
    localparam int WEFF_W    = $clog2(MAX_WIDTH + 1);
    localparam int HALF_MAX  = MAX_KERNEL / 2;
    localparam int LAG_MAX   = HALF_MAX * MAX_WIDTH + HALF_MAX;
    localparam int DIFF_W    = $clog2(LAG_MAX + 2);
    // even K sits one row and one column back from the newest, so the window spans 2*half+1
    localparam int WIN       = 2 * HALF_MAX + 1;
    localparam int NW        = WIN * WIN;
    localparam int MID       = NW / 2;
    localparam int NL        = NW;

    typedef logic [NW-1:0] mask_t;

    // Window positions outside a KxK window are padded so that element MID of the
    // full window is the KxK median: 0 on the positions marked here, 255 elsewhere.
    function automatic mask_t low_mask(input int k);
        mask_t m;
        int    pad;
        int    cnt;
        int    lo;
        int    hi;
        m   = '0;
        pad = MID - ((k * k) >> 1);
        cnt = 0;
        hi  = 2 * (k >> 1);
        lo  = hi + 1 - k;
        for (int i = 0; i < WIN; i++) begin
            for (int j = 0; j < WIN; j++) begin
                if (!(i >= lo && i <= hi && j >= lo && j <= hi)) begin
                    if (cnt < pad) begin
                        m[i * WIN + j] = 1'b1;
                    end
                    cnt++;
                end
            end
        end
        return m;
    endfunction

    mask_t low_tab [MAX_KERNEL + 1];
    for (genvar g = 0; g <= MAX_KERNEL; g++) begin : g_mask
        localparam mask_t M = low_mask(g);
        assign low_tab[g] = M;
    end

    // configuration
    logic [KSIZE_W-1:0]   kernel_size_reg;
    logic [IWIDTH_W-1:0]  image_width_reg;
    logic [IHEIGHT_W-1:0] image_height_reg;
    logic                 cfg_wr;
    logic                 cfg_hit;

    logic [KW-1:0]        k_eff;
    logic [KW-1:0]        half;
    logic [WEFF_W-1:0]    w_eff;
    logic [IHEIGHT_W-1:0] h_eff;
    logic [DIFF_W-1:0]    lag;

    // frame counters
    logic [IHEIGHT_W-1:0] in_row_reg, out_row_reg;
    logic [COL_W-1:0]     in_col_reg, out_col_reg;
    logic [SLOT_W-1:0]    in_slot_reg, out_slot_reg;
    logic [DIFF_W-1:0]    diff_reg;

    logic                 is_pix, in_done, restart, emit, advance, accepted;
    logic [IHEIGHT_W-1:0] b_in_row, b_out_row, in_row_adv, out_row_adv;
    logic [COL_W-1:0]     b_in_col, b_out_col, in_col_adv, out_col_adv;
    logic [SLOT_W-1:0]    b_in_slot, b_out_slot, in_slot_adv, out_slot_adv;
    logic [DIFF_W-1:0]    b_diff, diff_inc;
    logic                 in_col_wrap, out_col_wrap, frame_end, interior;

    // first stage, line store data arrives
    logic              s1_valid_reg, s1_is_pix_reg, s1_emit_reg, s1_interior_reg, s1_last_reg;
    logic [PIX_W-1:0]  s1_pix_reg;
    logic [SLOT_W-1:0] s1_inslot_reg, s1_outslot_reg;
    logic              s1_ready, s1_fire;

    logic [PIX_W-1:0]  ram_qa [ROW_SLOTS];
    logic [PIX_W-1:0]  ram_qb [ROW_SLOTS];
    logic [PIX_W-1:0]  col_vec [WIN];
    logic [PIX_W-1:0]  win_reg [WIN][WIN];
    logic [PIX_W-1:0]  win_next [WIN][WIN];
    logic [CH_W-1:0]   p0_data [NUM_CH][NW];
    mask_t             cur_low;

    // sorting pipeline
    logic              p_valid_reg [NL + 1];
    logic [CH_W-1:0]   p_data_reg [NL + 1][NUM_CH][NW];
    logic [PIX_W-1:0]  p_pass_reg [NL + 1];
    logic              p_int_reg [NL + 1];
    logic              p_last_reg [NL + 1];
    logic [CH_W-1:0]   layer_out [NL][NUM_CH][NW];
    logic              p_ready [NL + 1];

    logic              m_tvalid_reg, m_tlast_reg;
    logic [PIX_W-1:0]  m_tdata_reg;
    logic              out_ready;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        cfg_hit = 1'b0;
        prdata  = '0;
        unique case (cfg_idx_t'(paddr[3:2]))
            CFG_KERNEL_SIZE: begin
                cfg_hit = 1'b1;
                prdata  = APB_DW'(kernel_size_reg);
            end
            CFG_IMAGE_WIDTH: begin
                cfg_hit = 1'b1;
                prdata  = APB_DW'(image_width_reg);
            end
            CFG_IMAGE_HEIGHT: begin
                cfg_hit = 1'b1;
                prdata  = APB_DW'(image_height_reg);
            end
            default: begin
                cfg_hit = 1'b0;
                prdata  = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kernel_size_reg  <= KSIZE_RST;
            image_width_reg  <= IWIDTH_RST;
            image_height_reg <= IHEIGHT_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx_t'(paddr[3:2]))
                CFG_KERNEL_SIZE:  kernel_size_reg  <= pwdata[KSIZE_W-1:0];
                CFG_IMAGE_WIDTH:  image_width_reg  <= pwdata[IWIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= pwdata[IHEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (kernel_size_reg == '0) begin
            k_eff = KW'(1);
        end else if (int'(kernel_size_reg) > MAX_KERNEL) begin
            k_eff = KW'(MAX_KERNEL);
        end else begin
            k_eff = KW'(kernel_size_reg);
        end
        if (image_width_reg == '0) begin
            w_eff = WEFF_W'(1);
        end else if (int'(image_width_reg) > MAX_WIDTH) begin
            w_eff = WEFF_W'(MAX_WIDTH);
        end else begin
            w_eff = WEFF_W'(image_width_reg);
        end
        h_eff = (image_height_reg == '0) ? IHEIGHT_W'(1) : image_height_reg;
        half  = k_eff >> 1;
        lag   = DIFF_W'(int'(half) * int'(w_eff) + int'(half));
    end

    // ---------------- input side: counters ----------------
    assign accepted = s_tvalid && s_tready;
    assign s_tready = s1_ready;

    always_comb begin
        is_pix  = (s_tuser[0] == FUNC_PIXEL);
        in_done = (in_row_reg >= h_eff);
        // a pixel after the frame was fully input starts a new frame
        restart = is_pix && in_done;

        b_in_row   = restart ? '0 : in_row_reg;
        b_in_col   = restart ? '0 : in_col_reg;
        b_in_slot  = restart ? '0 : in_slot_reg;
        b_out_row  = restart ? '0 : out_row_reg;
        b_out_col  = restart ? '0 : out_col_reg;
        b_out_slot = restart ? '0 : out_slot_reg;
        b_diff     = restart ? '0 : diff_reg;

        diff_inc = b_diff + DIFF_W'(1);
        emit     = is_pix ? (diff_inc > lag) : in_done;
        advance  = is_pix || emit;

        // after the frame is input, flushes keep stepping the column pointer
        in_col_wrap = (int'(b_in_col) + 1 >= int'(w_eff));
        in_col_adv  = in_col_wrap ? '0 : b_in_col + COL_W'(1);
        if (in_col_wrap) begin
            in_slot_adv = (b_in_slot == SLOT_W'(ROW_SLOTS - 1)) ? '0 : b_in_slot + SLOT_W'(1);
        end else begin
            in_slot_adv = b_in_slot;
        end
        in_row_adv = (is_pix && in_col_wrap) ? b_in_row + IHEIGHT_W'(1) : b_in_row;

        out_col_wrap = (int'(b_out_col) + 1 >= int'(w_eff));
        out_col_adv  = out_col_wrap ? '0 : b_out_col + COL_W'(1);
        if (out_col_wrap) begin
            out_slot_adv = (b_out_slot == SLOT_W'(ROW_SLOTS - 1)) ? '0
                                                                 : b_out_slot + SLOT_W'(1);
        end else begin
            out_slot_adv = b_out_slot;
        end
        out_row_adv = out_col_wrap ? b_out_row + IHEIGHT_W'(1) : b_out_row;
        frame_end   = (out_row_adv == h_eff);

        interior = (int'(b_out_row) >= int'(half))
                && (int'(b_out_row) + int'(half) < int'(h_eff))
                && (int'(b_out_col) >= int'(half))
                && (int'(b_out_col) + int'(half) < int'(w_eff));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (cfg_wr && cfg_hit)) begin
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_slot_reg  <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_slot_reg <= '0;
            diff_reg     <= '0;
        end else if (accepted && advance) begin
            if (emit && frame_end) begin
                in_row_reg   <= '0;
                in_col_reg   <= '0;
                in_slot_reg  <= '0;
                out_row_reg  <= '0;
                out_col_reg  <= '0;
                out_slot_reg <= '0;
                diff_reg     <= '0;
            end else begin
                in_row_reg  <= in_row_adv;
                in_col_reg  <= in_col_adv;
                in_slot_reg <= in_slot_adv;
                if (is_pix) begin
                    diff_reg <= emit ? b_diff : diff_inc;
                end else begin
                    diff_reg <= b_diff;
                end
                if (emit) begin
                    out_row_reg  <= out_row_adv;
                    out_col_reg  <= out_col_adv;
                    out_slot_reg <= out_slot_adv;
                end else begin
                    out_row_reg  <= b_out_row;
                    out_col_reg  <= b_out_col;
                    out_slot_reg <= b_out_slot;
                end
            end
        end
    end

    // ---------------- line store: one row per slot ----------------
    for (genvar g = 0; g < ROW_SLOTS; g++) begin : g_line
        rwmf_ram #(
            .WIDTH(PIX_W),
            .DEPTH(MAX_WIDTH)
        ) u_ram (
            .clk    (aclk),
            .we     (accepted && is_pix && (b_in_slot == SLOT_W'(g))),
            .waddr  (b_in_col),
            .wdata  (s_tdata),
            .rea    (accepted && advance),
            .raddr_a(b_in_col),
            .rdata_a(ram_qa[g]),
            .reb    (accepted && emit),
            .raddr_b(b_out_col),
            .rdata_b(ram_qb[g])
        );
    end

    // ---------------- window stage ----------------
    assign s1_ready = !s1_valid_reg || !s1_emit_reg || p_ready[0];
    assign s1_fire  = s1_valid_reg && s1_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_ready) begin
            s1_valid_reg <= accepted && advance;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready && accepted) begin
            s1_pix_reg      <= s_tdata;
            s1_is_pix_reg   <= is_pix;
            s1_emit_reg     <= emit;
            s1_inslot_reg   <= b_in_slot;
            s1_outslot_reg  <= b_out_slot;
            s1_interior_reg <= interior;
            s1_last_reg     <= frame_end;
        end
    end

    // column of the newest rows; the row just written is taken from the input itself
    always_comb begin
        int sl;
        for (int i = 0; i < WIN; i++) begin
            sl = int'(s1_inslot_reg) - i;
            if (sl < 0) begin
                sl = sl + ROW_SLOTS;
            end
            if (i == 0 && s1_is_pix_reg) begin
                col_vec[i] = s1_pix_reg;
            end else begin
                col_vec[i] = ram_qa[SLOT_W'(sl)];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < WIN; i++) begin
            win_next[i][0] = col_vec[i];
            for (int j = 1; j < WIN; j++) begin
                win_next[i][j] = win_reg[i][j-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            for (int i = 0; i < WIN; i++) begin
                for (int j = 0; j < WIN; j++) begin
                    win_reg[i][j] <= win_next[i][j];
                end
            end
        end
    end

    assign cur_low = low_tab[k_eff];

    // the KxK window covers newest-relative rows and columns 2*half+1-K .. 2*half
    always_comb begin
        int lo;
        int hi;
        hi = 2 * int'(half);
        lo = hi + 1 - int'(k_eff);
        for (int ch = 0; ch < NUM_CH; ch++) begin
            for (int i = 0; i < WIN; i++) begin
                for (int j = 0; j < WIN; j++) begin
                    if (i >= lo && i <= hi && j >= lo && j <= hi) begin
                        p0_data[ch][i*WIN+j] = win_next[i][j][ch*CH_W +: CH_W];
                    end else if (cur_low[i*WIN+j]) begin
                        p0_data[ch][i*WIN+j] = '0;
                    end else begin
                        p0_data[ch][i*WIN+j] = '1;
                    end
                end
            end
        end
    end

    // ---------------- sorting network ----------------
    always_comb begin
        for (int s = 0; s < NL; s++) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                for (int e = 0; e < NW; e++) begin
                    layer_out[s][ch][e] = p_data_reg[s][ch][e];
                end
                for (int m = (s & 1); m + 1 < NW; m += 2) begin
                    if (p_data_reg[s][ch][m] > p_data_reg[s][ch][m+1]) begin
                        layer_out[s][ch][m]   = p_data_reg[s][ch][m+1];
                        layer_out[s][ch][m+1] = p_data_reg[s][ch][m];
                    end
                end
            end
        end
    end

    assign out_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        p_ready[NL] = !p_valid_reg[NL] || out_ready;
        for (int s = NL - 1; s >= 0; s--) begin
            p_ready[s] = !p_valid_reg[s] || p_ready[s+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s <= NL; s++) begin
                p_valid_reg[s] <= 1'b0;
            end
        end else begin
            if (p_ready[0]) begin
                p_valid_reg[0] <= s1_valid_reg && s1_emit_reg;
            end
            for (int s = 0; s < NL; s++) begin
                if (p_ready[s+1]) begin
                    p_valid_reg[s+1] <= p_valid_reg[s];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (p_ready[0]) begin
            p_data_reg[0] <= p0_data;
            p_pass_reg[0] <= ram_qb[s1_outslot_reg];
            p_int_reg[0]  <= s1_interior_reg;
            p_last_reg[0] <= s1_last_reg;
        end
        for (int s = 0; s < NL; s++) begin
            if (p_ready[s+1]) begin
                p_data_reg[s+1] <= layer_out[s];
                p_pass_reg[s+1] <= p_pass_reg[s];
                p_int_reg[s+1]  <= p_int_reg[s];
                p_last_reg[s+1] <= p_last_reg[s];
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_ready) begin
            m_tvalid_reg <= p_valid_reg[NL];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready) begin
            m_tlast_reg <= p_last_reg[NL];
            for (int ch = 0; ch < NUM_CH; ch++) begin
                m_tdata_reg[ch*CH_W +: CH_W] <= p_int_reg[NL] ? p_data_reg[NL][ch][MID]
                                                              : p_pass_reg[NL][ch*CH_W +: CH_W];
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ----- hw/rtl/rwmf_ram.sv -----
module rwmf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             rea,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic             reb,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (rea) begin
            rdata_a_reg <= mem_reg[raddr_a];
        end
        if (reb) begin
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ----- tb/rgb_window_median_filter_tb.sv -----
module rgb_window_median_filter_tb;
    import rwmf_pkg::*;

    localparam logic FUNC_FLUSH = ~FUNC_PIXEL;
    localparam int   ROW_SLOTS  = MAX_KERNEL_DEF + 1;
    localparam int   SETTLE     = MAX_KERNEL_DEF * MAX_KERNEL_DEF + 20;
    localparam int   STALL_LIMIT = 4000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } pixel_out_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [PIX_W-1:0]  s_tdata = '0;   // blue_in, green_in, red_in
    logic [0:0]        s_tuser = '0;   // func
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [PIX_W-1:0]  m_tdata;        // blue_out, green_out, red_out
    logic              m_tlast;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    rgb_window_median_filter dut (.*);

    // filter model state
    logic [KSIZE_W-1:0]   kernel_reg;
    logic [IWIDTH_W-1:0]  width_reg;
    logic [IHEIGHT_W-1:0] height_reg;
    logic [PIX_W-1:0]     row_mem [ROW_SLOTS][MAX_WIDTH_DEF];
    int unsigned          in_row, in_col, out_row, out_col;

    pixel_out_t expected_pixels[$];
    int errors = 0;
    int pixels_sent = 0;
    int pixels_seen = 0;
    int frames_done = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;

    initial begin
        forever #10 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic int unsigned eff_kernel();
        if (kernel_reg == 0) return 1;
        if (kernel_reg > MAX_KERNEL_DEF) return MAX_KERNEL_DEF;
        return int'(kernel_reg);
    endfunction

    function automatic int unsigned eff_width();
        if (width_reg == 0) return 1;
        if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
        return int'(width_reg);
    endfunction

    function automatic int unsigned eff_height();
        return (height_reg == 0) ? 1 : int'(height_reg);
    endfunction

    function automatic void clear_position();
        in_row = 0; in_col = 0; out_row = 0; out_col = 0;
    endfunction

    // median of the window around the current output position, or pass-through
    function automatic pixel_out_t median_pixel();
        int unsigned kk, ww, hh, half, r, c, n, kr, kc, i, j;
        logic [7:0]  vals [MAX_KERNEL_DEF*MAX_KERNEL_DEF];
        logic [7:0]  v;
        logic [PIX_W-1:0] p, res;
        pixel_out_t  o;
        kk = eff_kernel(); ww = eff_width(); hh = eff_height();
        half = kk / 2; r = out_row; c = out_col;
        res = row_mem[r % ROW_SLOTS][c % MAX_WIDTH_DEF];
        if (r >= half && r + half < hh && c >= half && c + half < ww) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                n = 0;
                for (kr = 0; kr < kk; kr++)
                    for (kc = 0; kc < kk; kc++) begin
                        p = row_mem[(r + kr - half) % ROW_SLOTS][(c + kc - half) % MAX_WIDTH_DEF];
                        vals[n] = p[8*ch +: 8];
                        n++;
                    end
                for (i = 1; i < n; i++) begin
                    v = vals[i];
                    j = i;
                    while (j > 0 && vals[j-1] > v) begin
                        vals[j] = vals[j-1];
                        j--;
                    end
                    vals[j] = v;
                end
                res[8*ch +: 8] = vals[n/2];
            end
        end
        o.blue = res[7:0]; o.green = res[15:8]; o.red = res[23:16];
        out_col++;
        if (out_col >= ww) begin
            out_col = 0;
            out_row++;
        end
        o.last = (out_row >= hh);
        if (o.last) clear_position();
        return o;
    endfunction

    // advance the model by one accepted transaction; returns 1 if it yields a pixel
    function automatic bit filter_step(input logic func, input logic [PIX_W-1:0] pix,
                                       output pixel_out_t o);
        int unsigned kk, ww, hh, half, total, lag, inpos, outpos;
        kk = eff_kernel(); ww = eff_width(); hh = eff_height();
        half = kk / 2; total = ww * hh; lag = half * ww + half;
        inpos = in_row * ww + in_col;
        outpos = out_row * ww + out_col;
        if (func == FUNC_PIXEL) begin
            if (inpos >= total) begin
                clear_position();
                inpos = 0; outpos = 0;
            end
            row_mem[in_row % ROW_SLOTS][in_col % MAX_WIDTH_DEF] = pix;
            in_col++;
            if (in_col >= ww) begin
                in_col = 0;
                in_row++;
            end
            inpos++;
            if (inpos - outpos > lag) begin
                o = median_pixel();
                return 1;
            end
            return 0;
        end
        if (inpos >= total && outpos < total) begin
            o = median_pixel();
            return 1;
        end
        return 0;
    endfunction

    task automatic send_item(input logic func, input logic [PIX_W-1:0] pix);
        pixel_out_t o;
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = func;
        s_tdata  = pix;
        do @(posedge aclk); while (!s_tready);
        if (filter_step(func, pix, o)) begin
            expected_pixels.push_back(o);
            if (o.last) frames_done++;
        end
        if (func == FUNC_PIXEL) pixels_sent++;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_pixels.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic apb_access(input cfg_idx_t idx, input bit wr, input logic [APB_DW-1:0] wdata,
                              output logic [APB_DW-1:0] rdata);
        @(negedge aclk);
        psel = 1'b1; penable = 1'b0; pwrite = wr;
        paddr = APB_AW'(4 * int'(idx)); pwdata = wdata;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        @(negedge aclk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    // block must be idle; the write restarts the frame
    task automatic write_reg(input cfg_idx_t idx, input int unsigned value);
        logic [APB_DW-1:0] rd, want;
        apb_access(idx, 1'b1, value, rd);
        case (idx)
            CFG_KERNEL_SIZE: begin
                kernel_reg = KSIZE_W'(value);
                want = APB_DW'(kernel_reg);
            end
            CFG_IMAGE_WIDTH: begin
                width_reg = IWIDTH_W'(value);
                want = APB_DW'(width_reg);
            end
            default: begin
                height_reg = IHEIGHT_W'(value);
                want = APB_DW'(height_reg);
            end
        endcase
        clear_position();
        apb_access(idx, 1'b0, '0, rd);
        if (rd != want) report_mismatch("register readback", rd, want);
    endtask

    task automatic set_geometry(input int unsigned k, input int unsigned w, input int unsigned h);
        write_reg(CFG_KERNEL_SIZE, k);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
    endtask

    task automatic send_frame(input int unsigned npix, input int unsigned nflush, input bit noisy);
        for (int unsigned i = 0; i < npix; i++) begin
            if (noisy && $urandom_range(0, 19) == 0) send_item(FUNC_FLUSH, PIX_W'($urandom));
            send_item(FUNC_PIXEL, PIX_W'($urandom));
        end
        for (int unsigned i = 0; i < nflush; i++) send_item(FUNC_FLUSH, PIX_W'($urandom));
    endtask

    always @(negedge aclk) m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            pixels_seen++;
            if (expected_pixels.size() == 0) begin
                report_mismatch("unexpected pixel", int'(m_tdata), 0);
            end else begin
                pixel_out_t e;
                e = expected_pixels.pop_front();
                if (m_tdata[7:0] != e.blue)
                    report_mismatch("blue", int'(m_tdata[7:0]), int'(e.blue));
                if (m_tdata[15:8] != e.green)
                    report_mismatch("green", int'(m_tdata[15:8]), int'(e.green));
                if (m_tdata[23:16] != e.red)
                    report_mismatch("red", int'(m_tdata[23:16]), int'(e.red));
                if (m_tlast != e.last)
                    report_mismatch("frame end", int'(m_tlast), int'(e.last));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("stalled: %0d results still pending", expected_pixels.size());
            $display("FAIL");
            $finish;
        end
    end

    task automatic test_directed();
        // all-zero, all-one and alternating pixels in a 3x3 frame; early flush is ignored
        set_geometry(3, 3, 3);
        send_item(FUNC_FLUSH, '1);
        send_item(FUNC_PIXEL, 24'h000000);
        send_item(FUNC_PIXEL, 24'hFFFFFF);
        send_item(FUNC_PIXEL, 24'hAA55AA);
        send_item(FUNC_PIXEL, 24'h55AA55);
        send_item(FUNC_PIXEL, 24'h0F00F0);
        send_item(FUNC_PIXEL, 24'hFFFFFF);
        send_item(FUNC_PIXEL, 24'h000000);
        send_item(FUNC_PIXEL, 24'h807F01);
        send_item(FUNC_PIXEL, 24'hFE0180);
        send_frame(0, 5, 0);
        wait_drained();
        // image too small for any interior: everything passes through
        set_geometry(5, 2, 2);
        send_frame(4, 5, 0);
        wait_drained();
    endtask

    task automatic test_register_extremes();
        // out-of-range values clamp; height at its top is abandoned by the next write
        set_geometry(0, 0, 0);
        send_frame(1, 1, 0);
        wait_drained();
        set_geometry(7, 2047, 65535);
        send_frame(40, 2, 0);
        wait_drained();
        set_geometry(1, 1030, 1);
        send_frame(40, 1, 0);
        wait_drained();
        set_geometry(5, 1024, 5);
        send_frame(30, 0, 0);
        wait_drained();
    endtask

    task automatic test_random(input int target);
        int unsigned k, w, h, total, lag, half, kk;
        int start;
        start = pixels_sent + pixels_seen;
        while (pixels_sent + pixels_seen - start < target) begin
            wait_drained();
            k = $urandom_range(0, 9) == 0 ? $urandom_range(0, 7) : $urandom_range(1, 5);
            w = $urandom_range(0, 15) == 0 ? $urandom_range(0, 2) : $urandom_range(1, 9);
            h = $urandom_range(0, 15) == 0 ? 0 : $urandom_range(1, 8);
            set_geometry(k, w, h);
            kk = eff_kernel(); half = kk / 2;
            total = eff_width() * eff_height();
            lag = half * eff_width() + half;
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 9))
                    0: send_frame($urandom_range(0, total - 1), $urandom_range(0, 2), 1);
                    1: send_frame(total, $urandom_range(0, lag), 1);
                    default: send_frame(total, (lag < total ? lag : total) +
                                        $urandom_range(0, 1), $urandom_range(0, 3) == 0);
                endcase
            end
        end
    endtask

    initial begin
        kernel_reg = KSIZE_RST; width_reg = IWIDTH_RST; height_reg = IHEIGHT_RST;
        clear_position();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_register_extremes();
        send_idle_pct = 12; recv_stall_pct = 68;
        test_random(170);
        send_idle_pct = 68; recv_stall_pct = 12;
        test_random(170);
        send_idle_pct = 0; recv_stall_pct = 0;
        test_random(170);

        wait_drained();
        $display("covered %0d pixels in, %0d filtered pixels out, %0d complete frames",
                 pixels_sent, pixels_seen, frames_done);
        $display("kernel sizes 0..7, widths 0..2047, heights 0..65535, flush and restart cases");
        if (errors == 0 && expected_pixels.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
